// File: hw/rtl/obdt_pkg.sv
`timescale 1ns / 1ps
package obdt_pkg;
    localparam int BookDepth = 64;
    localparam int TopLevels = 5;
    localparam int PW = 48;
    localparam int IW = 64;

    localparam logic [2:0] CMD_SNAP_START = 3'd0;
    localparam logic [2:0] CMD_SNAP_LEVEL = 3'd1;
    localparam logic [2:0] CMD_UPD_START  = 3'd2;
    localparam logic [2:0] CMD_UPD_LEVEL  = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_QUERY      = 3'd5;

    localparam logic [2:0] ST_APPLIED = 3'd0;
    localparam logic [2:0] ST_SKIPPED = 3'd1;
    localparam logic [2:0] ST_GAP     = 3'd2;
    localparam logic [2:0] ST_IGNORED = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]    command;
        logic          side;
        logic [PW-1:0] price;
        logic [PW-1:0] quantity;
        logic [IW-1:0] first_id;
        logic [IW-1:0] final_id;
        logic [IW-1:0] previous_id;
        logic          first_present;
        logic          final_present;
        logic          previous_present;
    } t_req;

    typedef struct packed {
        logic [2:0]    status;
        logic          out_side;
        logic [2:0]    rank;
        logic [PW-1:0] out_price;
        logic [PW-1:0] out_quantity;
        logic          last;
    } t_rsp;

    // operation broadcast along the cell chain
    typedef struct packed {
        logic          clear;
        logic          ins;   // insert at first position where new price is ahead
        logic          del;   // remove matching price, shift up
        logic          set;   // replace quantity of matching price
        logic          side;
        logic [PW-1:0] price;
        logic [PW-1:0] qty;
    } t_op;
endpackage

// File: hw/rtl/obdt_if.sv
`timescale 1ns / 1ps
interface obdt_req_if;
    logic             valid;
    logic             ready;
    obdt_pkg::t_req   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface obdt_rsp_if;
    logic             valid;
    logic             ready;
    obdt_pkg::t_rsp   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/order_book_depth_tracker_top.sv
`timescale 1ns / 1ps
// order book depth tracker
// i_req carries commands (snapshot start/level, update start/level, clear, query);
// o_rsp carries results with a last flag closing each request's results.
// each side is a chain of BOOK_DEPTH cells kept sorted best first; a level
// insert, replace or erase is applied to every cell in parallel, each cell
// taking its neighbor's entry where the order shifts.
// when a request is taken, its result appears in the output register the
// next cycle; a non-query request gives one result.
// a query gives 2*TOP_LEVELS results, bid ranks then ask ranks, read from
// the head cells one result per cycle while the receiver takes them.
// throughput: one request per cycle for non-query traffic; a query holds the
// input until its last result is registered. the output register holds while
// the receiver stalls, and no new request is taken until the held result leaves.
// synchronous reset empties both sides and clears all sequence state; ready
// is low during reset and requests are taken once reset is released.
module order_book_depth_tracker_top #(
    parameter int BOOK_DEPTH = obdt_pkg::BookDepth,
    parameter int TOP_LEVELS = obdt_pkg::TopLevels
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obdt_req_if.sink    i_req,
    obdt_rsp_if.source  o_rsp
);
    localparam int NQ = 2 * TOP_LEVELS;
    localparam int QW = $clog2(NQ + 1);
    localparam int RW = (TOP_LEVELS > 1) ? $clog2(TOP_LEVELS) : 1;

    typedef enum logic [0:0] {S_RUN, S_QUERY} t_state;

    t_state                  r_state;
    logic [QW-1:0]           r_qidx;
    logic                    r_ovalid;
    obdt_pkg::t_rsp          r_odata;
    logic [obdt_pkg::IW-1:0] r_last_id;
    logic                    r_last_valid;
    logic                    r_live;
    logic                    r_stale;
    logic                    r_accept;

    t_state                  n_state;
    logic [QW-1:0]           n_qidx;
    logic                    n_ovalid;
    obdt_pkg::t_rsp          n_odata;
    logic [obdt_pkg::IW-1:0] n_last_id;
    logic                    n_last_valid;
    logic                    n_live;
    logic                    n_stale;
    logic                    n_accept;

    obdt_pkg::t_op           w_op;
    logic                    w_fire;
    logic                    w_slot;
    obdt_pkg::t_req          w_r;
    logic [1:0]              w_found;
    logic [1:0]              w_full;
    logic [BOOK_DEPTH-1:0][obdt_pkg::PW-1:0] w_bp, w_bq, w_ap, w_aq;
    logic [BOOK_DEPTH-1:0]   w_bv, w_av;
    logic                    w_sfound;
    logic                    w_sfull;
    logic [2:0]              w_lvl_status;
    logic [2:0]              w_us_status;
    logic [obdt_pkg::IW-1:0] w_want;

    assign w_r    = i_req.data;
    assign w_slot = !r_ovalid || o_rsp.ready;
    assign i_req.ready = i_rst_n && (r_state == S_RUN) && w_slot;
    assign w_fire = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    assign w_sfound = w_r.side ? w_found[1] : w_found[0];
    assign w_sfull  = w_r.side ? w_full[1]  : w_full[0];
    assign w_want   = r_last_id + 1'b1;

    always_comb begin
        w_op       = '0;
        w_op.side  = w_r.side;
        w_op.price = w_r.price;
        w_op.qty   = w_r.quantity;
        w_lvl_status = obdt_pkg::ST_IGNORED;
        if (w_r.command == obdt_pkg::CMD_SNAP_LEVEL || w_r.command == obdt_pkg::CMD_UPD_LEVEL)
        begin
            if (!r_accept) begin
                w_lvl_status = obdt_pkg::ST_IGNORED;
            end else if (w_r.quantity == '0) begin
                if (w_r.command == obdt_pkg::CMD_UPD_LEVEL) begin
                    w_lvl_status = obdt_pkg::ST_APPLIED;
                    w_op.del = w_fire && w_sfound;
                end
            end else if (w_sfound) begin
                w_lvl_status = obdt_pkg::ST_APPLIED;
                w_op.set = w_fire;
            end else if (w_sfull) begin
                w_lvl_status = obdt_pkg::ST_FULL;
            end else begin
                w_lvl_status = obdt_pkg::ST_APPLIED;
                w_op.ins = w_fire;
            end
        end
        w_op.clear = w_fire && (w_r.command == obdt_pkg::CMD_SNAP_START ||
                                w_r.command == obdt_pkg::CMD_CLEAR);
    end

    always_comb begin
        w_us_status = obdt_pkg::ST_APPLIED;
        if (!r_live || r_stale) begin
            w_us_status = obdt_pkg::ST_SKIPPED;
        end else if (r_last_valid) begin
            if (w_r.final_present && w_r.final_id <= r_last_id) begin
                w_us_status = obdt_pkg::ST_SKIPPED;
            end else if (w_r.previous_present) begin
                if (w_r.previous_id != r_last_id) w_us_status = obdt_pkg::ST_GAP;
            end else if (w_r.first_present && w_r.final_present) begin
                if (!(w_r.first_id <= w_want && w_want <= w_r.final_id))
                    w_us_status = obdt_pkg::ST_GAP;
            end
        end
    end

    obdt_chain #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_side(1'b0), .i_op(w_op),
        .o_found(w_found[0]), .o_full(w_full[0]),
        .o_price(w_bp), .o_qty(w_bq), .o_valid(w_bv)
    );
    obdt_chain #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_side(1'b1), .i_op(w_op),
        .o_found(w_found[1]), .o_full(w_full[1]),
        .o_price(w_ap), .o_qty(w_aq), .o_valid(w_av)
    );

    // query read of the head cells
    logic                 w_qside;
    logic [RW-1:0]        w_qrank;
    logic                 w_qhave;
    logic [obdt_pkg::PW-1:0] w_qp, w_qq;
    always_comb begin
        w_qside = (r_qidx >= QW'(TOP_LEVELS));
        w_qrank = w_qside ? RW'(r_qidx - QW'(TOP_LEVELS)) : RW'(r_qidx);
        w_qhave = 1'b0;
        w_qp    = '0;
        w_qq    = '0;
        for (int k = 0; k < TOP_LEVELS; k++) begin
            if (RW'(k) == w_qrank && k < BOOK_DEPTH) begin
                w_qhave = w_qside ? w_av[k] : w_bv[k];
                w_qp    = w_qside ? w_ap[k] : w_bp[k];
                w_qq    = w_qside ? w_aq[k] : w_bq[k];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_qidx       = r_qidx;
        n_ovalid     = r_ovalid && !o_rsp.ready;
        n_odata      = r_odata;
        n_last_id    = r_last_id;
        n_last_valid = r_last_valid;
        n_live       = r_live;
        n_stale      = r_stale;
        n_accept     = r_accept;
        unique case (r_state)
            S_RUN: begin
                if (w_fire) begin
                    n_ovalid      = 1'b1;
                    n_odata       = '0;
                    n_odata.last  = 1'b1;
                    unique case (w_r.command)
                        obdt_pkg::CMD_SNAP_START: begin
                            if (w_r.final_present) begin
                                n_last_id    = w_r.final_id;
                                n_last_valid = 1'b1;
                            end
                            n_live   = 1'b1;
                            n_stale  = 1'b0;
                            n_accept = 1'b1;
                            n_odata.status = obdt_pkg::ST_APPLIED;
                        end
                        obdt_pkg::CMD_SNAP_LEVEL, obdt_pkg::CMD_UPD_LEVEL: begin
                            n_odata.status = w_lvl_status;
                        end
                        obdt_pkg::CMD_UPD_START: begin
                            n_odata.status = w_us_status;
                            n_accept = (w_us_status == obdt_pkg::ST_APPLIED);
                            if (w_us_status == obdt_pkg::ST_APPLIED &&
                                w_r.final_present) begin
                                n_last_id    = w_r.final_id;
                                n_last_valid = 1'b1;
                            end
                        end
                        obdt_pkg::CMD_CLEAR: begin
                            n_live       = 1'b0;
                            n_stale      = 1'b1;
                            n_last_valid = 1'b0;
                            n_accept     = 1'b0;
                            n_odata.status = obdt_pkg::ST_APPLIED;
                        end
                        obdt_pkg::CMD_QUERY: begin
                            n_ovalid = 1'b0;
                            n_qidx   = '0;
                            n_state  = S_QUERY;
                        end
                        default: n_odata.status = obdt_pkg::ST_IGNORED;
                    endcase
                end
            end
            S_QUERY: begin
                if (w_slot) begin
                    n_ovalid             = 1'b1;
                    n_odata.status       = obdt_pkg::ST_APPLIED;
                    n_odata.out_side     = w_qside;
                    n_odata.rank         = 3'(w_qrank);
                    n_odata.out_price    = w_qhave ? w_qp : '0;
                    n_odata.out_quantity = w_qhave ? w_qq : '0;
                    n_odata.last         = (r_qidx == QW'(NQ - 1));
                    if (r_qidx == QW'(NQ - 1)) begin
                        n_state = S_RUN;
                    end
                    n_qidx = r_qidx + 1'b1;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_qidx       <= '0;
            r_ovalid     <= 1'b0;
            r_odata      <= '0;
            r_last_id    <= '0;
            r_last_valid <= 1'b0;
            r_live       <= 1'b0;
            r_stale      <= 1'b0;
            r_accept     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_qidx       <= n_qidx;
            r_ovalid     <= n_ovalid;
            r_odata      <= n_odata;
            r_last_id    <= n_last_id;
            r_last_valid <= n_last_valid;
            r_live       <= n_live;
            r_stale      <= n_stale;
            r_accept     <= n_accept;
        end
    end
endmodule

// File: hw/rtl/obdt_cell.sv
`timescale 1ns / 1ps
module obdt_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  obdt_pkg::t_op            i_op,
    input  logic                     i_side,   // side this chain keeps
    // neighbor toward best
    input  logic                     i_prev_valid,
    input  logic                     i_prev_ahead,  // insert decision at or before previous cell
    input  logic                     i_prev_match,  // match at or before previous cell
    input  logic [obdt_pkg::PW-1:0]  i_prev_price,
    input  logic [obdt_pkg::PW-1:0]  i_prev_qty,
    // neighbor toward worse
    input  logic                     i_next_valid,
    input  logic [obdt_pkg::PW-1:0]  i_next_price,
    input  logic [obdt_pkg::PW-1:0]  i_next_qty,
    output logic                     o_valid,
    output logic                     o_ahead,
    output logic                     o_match,
    output logic                     o_hit,
    output logic [obdt_pkg::PW-1:0]  o_price,
    output logic [obdt_pkg::PW-1:0]  o_qty
);
    logic                    r_valid;
    logic [obdt_pkg::PW-1:0] r_price;
    logic [obdt_pkg::PW-1:0] r_qty;
    logic                    w_mine;
    logic                    w_beats;
    logic                    w_hit;

    assign w_mine  = (i_op.side == i_side);
    assign w_hit   = r_valid && (r_price == i_op.price);
    // new price belongs at or before this cell
    assign w_beats = !r_valid ||
                     (i_side ? (i_op.price < r_price) : (i_op.price > r_price));
    assign o_ahead = w_beats;
    assign o_match = i_prev_match || w_hit;
    assign o_hit   = w_hit;
    assign o_valid = r_valid;
    assign o_price = r_price;
    assign o_qty   = r_qty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.clear) begin
            r_valid <= 1'b0;
        end else if (w_mine && i_op.ins) begin
            if (i_prev_ahead) begin
                r_valid <= i_prev_valid;
                r_price <= i_prev_price;
                r_qty   <= i_prev_qty;
            end else if (w_beats) begin
                r_valid <= 1'b1;
                r_price <= i_op.price;
                r_qty   <= i_op.qty;
            end
        end else if (w_mine && i_op.del) begin
            if (o_match) begin
                r_valid <= i_next_valid;
                r_price <= i_next_price;
                r_qty   <= i_next_qty;
            end
        end else if (w_mine && i_op.set && w_hit) begin
            r_qty <= i_op.qty;
        end
    end
endmodule

// File: hw/rtl/obdt_chain.sv
`timescale 1ns / 1ps
module obdt_chain #(
    parameter int BOOK_DEPTH = obdt_pkg::BookDepth
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_side,
    input  obdt_pkg::t_op                           i_op,
    output logic                                    o_found,
    output logic                                    o_full,
    output logic [BOOK_DEPTH-1:0][obdt_pkg::PW-1:0] o_price,
    output logic [BOOK_DEPTH-1:0][obdt_pkg::PW-1:0] o_qty,
    output logic [BOOK_DEPTH-1:0]                   o_valid
);
    logic [BOOK_DEPTH:0]   w_ahead;
    logic [BOOK_DEPTH:0]   w_match;
    logic [BOOK_DEPTH-1:0] w_hit;

    assign w_ahead[0] = 1'b0;
    assign w_match[0] = 1'b0;

    for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
        logic                    w_pv;
        logic [obdt_pkg::PW-1:0] w_pp;
        logic [obdt_pkg::PW-1:0] w_pq;
        logic                    w_nv;
        logic [obdt_pkg::PW-1:0] w_np;
        logic [obdt_pkg::PW-1:0] w_nq;
        logic                    w_pa;
        if (g == 0) begin : g_head
            assign w_pv = 1'b0;
            assign w_pp = '0;
            assign w_pq = '0;
            assign w_pa = 1'b0;
        end else begin : g_mid
            assign w_pv = o_valid[g-1];
            assign w_pp = o_price[g-1];
            assign w_pq = o_qty[g-1];
            // shift only when an earlier cell takes the new level
            assign w_pa = w_ahead[g];
        end
        if (g == BOOK_DEPTH - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_np = '0;
            assign w_nq = '0;
        end else begin : g_body
            assign w_nv = o_valid[g+1];
            assign w_np = o_price[g+1];
            assign w_nq = o_qty[g+1];
        end
        logic w_a;
        obdt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_side       (i_side),
            .i_prev_valid (w_pv),
            .i_prev_ahead (w_pa),
            .i_prev_match (w_match[g]),
            .i_prev_price (w_pp),
            .i_prev_qty   (w_pq),
            .i_next_valid (w_nv),
            .i_next_price (w_np),
            .i_next_qty   (w_nq),
            .o_valid      (o_valid[g]),
            .o_ahead      (w_a),
            .o_match      (w_match[g+1]),
            .o_hit        (w_hit[g]),
            .o_price      (o_price[g]),
            .o_qty        (o_qty[g])
        );
        // sticky: once a cell wants the new level, all later cells shift
        assign w_ahead[g+1] = w_ahead[g] || w_a;
    end

    assign o_found = |w_hit;
    assign o_full  = o_valid[BOOK_DEPTH-1];
endmodule

// File: tb/sv/order_book_depth_tracker_top_tb.sv
`timescale 1ns / 1ps
module order_book_depth_tracker_top_tb;

    localparam int NUM_RANDOM = 220;

    typedef struct {
        logic [2:0]    cmd;
        logic          side;
        logic [47:0]   price;
        logic [47:0]   qty;
        logic [63:0]   first_id;
        logic [63:0]   final_id;
        logic [63:0]   prev_id;
        logic [2:0]    present;   // first, final, previous
        int            want;      // typed-in status, -1 when the book model decides
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    obdt_req_if req_bus();
    obdt_rsp_if rsp_bus();

    order_book_depth_tracker_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_bus.sink),
        .o_rsp(rsp_bus.source)
    );

    always #1 i_clk = ~i_clk;

    // book mirror
    logic [47:0] bid_px[$], bid_qt[$], ask_px[$], ask_qt[$];
    logic [63:0] seen_id;
    bit          seen_ok, live, stale, levels_on;
    obdt_pkg::t_rsp expected_rsp[$];
    int          fail_count;
    int          rsp_count;
    int          status_hits[8];

    function automatic bit better(bit s, logic [47:0] a, logic [47:0] b);
        return s ? (a < b) : (a > b);
    endfunction

    function automatic logic [2:0] apply_level(bit s, logic [47:0] p, logic [47:0] q,
                                               bit erase);
        int pos;
        int n;
        bit hit;
        pos = -1;
        hit = 0;
        n = s ? ask_px.size() : bid_px.size();
        for (int i = 0; i < n; i++) begin
            logic [47:0] cur;
            cur = s ? ask_px[i] : bid_px[i];
            if (cur == p) begin
                hit = 1;
                pos = i;
                break;
            end
            if (better(s, p, cur)) begin
                pos = i;
                break;
            end
        end
        if (pos < 0) pos = n;
        if (q == 0) begin
            if (!erase) return obdt_pkg::ST_IGNORED;
            if (hit) begin
                if (s) begin
                    ask_px.delete(pos);
                    ask_qt.delete(pos);
                end else begin
                    bid_px.delete(pos);
                    bid_qt.delete(pos);
                end
            end
            return obdt_pkg::ST_APPLIED;
        end
        if (hit) begin
            if (s) ask_qt[pos] = q;
            else bid_qt[pos] = q;
            return obdt_pkg::ST_APPLIED;
        end
        if (n >= obdt_pkg::BookDepth) return obdt_pkg::ST_FULL;
        if (s) begin
            ask_px.insert(pos, p);
            ask_qt.insert(pos, q);
        end else begin
            bid_px.insert(pos, p);
            bid_qt.insert(pos, q);
        end
        return obdt_pkg::ST_APPLIED;
    endfunction

    function automatic logic [2:0] sequence_check(obdt_pkg::t_req r);
        logic [63:0] nxt;
        levels_on = 0;
        if (!live || stale) return obdt_pkg::ST_SKIPPED;
        if (seen_ok) begin
            if (r.final_present && r.final_id <= seen_id) return obdt_pkg::ST_SKIPPED;
            if (r.previous_present) begin
                if (r.previous_id != seen_id) return obdt_pkg::ST_GAP;
            end else if (r.first_present && r.final_present) begin
                nxt = seen_id + 64'd1;
                if (!(r.first_id <= nxt && nxt <= r.final_id)) return obdt_pkg::ST_GAP;
            end
        end
        if (r.final_present) begin
            seen_id = r.final_id;
            seen_ok = 1;
        end
        levels_on = 1;
        return obdt_pkg::ST_APPLIED;
    endfunction

    task automatic predict_book(obdt_pkg::t_req r);
        obdt_pkg::t_rsp o;
        o = '0;
        o.last = 1'b1;
        if (r.command == obdt_pkg::CMD_QUERY) begin
            for (int k = 0; k < 2 * obdt_pkg::TopLevels; k++) begin
                int rk;
                bit s;
                rk = k % obdt_pkg::TopLevels;
                s = k >= obdt_pkg::TopLevels;
                o = '0;
                o.out_side = s;
                o.rank = rk[2:0];
                if (s && rk < ask_px.size()) begin
                    o.out_price = ask_px[rk];
                    o.out_quantity = ask_qt[rk];
                end else if (!s && rk < bid_px.size()) begin
                    o.out_price = bid_px[rk];
                    o.out_quantity = bid_qt[rk];
                end
                o.last = (k == 2 * obdt_pkg::TopLevels - 1);
                expected_rsp.push_back(o);
            end
            return;
        end
        case (r.command)
            obdt_pkg::CMD_SNAP_START: begin
                bid_px.delete(); bid_qt.delete(); ask_px.delete(); ask_qt.delete();
                if (r.final_present) begin
                    seen_id = r.final_id;
                    seen_ok = 1;
                end
                live = 1;
                stale = 0;
                levels_on = 1;
                o.status = obdt_pkg::ST_APPLIED;
            end
            obdt_pkg::CMD_SNAP_LEVEL:
                o.status = levels_on ? apply_level(r.side, r.price, r.quantity, 0)
                                     : obdt_pkg::ST_IGNORED;
            obdt_pkg::CMD_UPD_START: o.status = sequence_check(r);
            obdt_pkg::CMD_UPD_LEVEL:
                o.status = levels_on ? apply_level(r.side, r.price, r.quantity, 1)
                                     : obdt_pkg::ST_IGNORED;
            obdt_pkg::CMD_CLEAR: begin
                bid_px.delete(); bid_qt.delete(); ask_px.delete(); ask_qt.delete();
                live = 0;
                stale = 1;
                seen_ok = 0;
                levels_on = 0;
                o.status = obdt_pkg::ST_APPLIED;
            end
            default: o.status = obdt_pkg::ST_IGNORED;
        endcase
        expected_rsp.push_back(o);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(obdt_pkg::t_req r, int want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data <= r;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predict_book(r);
        if (want >= 0 && expected_rsp[$].status != want[2:0]) begin
            $error("directed status: expected %0d, model gives %0d", want,
                   expected_rsp[$].status);
            fail_count++;
        end
    endtask

    // receiver with random stalls
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            obdt_pkg::t_rsp got, exp;
            got = rsp_bus.data;
            rsp_count++;
            if (expected_rsp.size() == 0) begin
                $error("result with nothing expected: %p", got);
                fail_count++;
            end else begin
                exp = expected_rsp.pop_front();
                status_hits[got.status]++;
                if (got.status != exp.status) begin
                    $error("status: expected %0d, actual %0d", exp.status, got.status);
                    fail_count++;
                end
                if (got.out_side != exp.out_side) begin
                    $error("out_side: expected %0d, actual %0d", exp.out_side, got.out_side);
                    fail_count++;
                end
                if (got.rank != exp.rank) begin
                    $error("rank: expected %0d, actual %0d", exp.rank, got.rank);
                    fail_count++;
                end
                if (got.out_price != exp.out_price) begin
                    $error("out_price: expected %0h, actual %0h", exp.out_price,
                           got.out_price);
                    fail_count++;
                end
                if (got.out_quantity != exp.out_quantity) begin
                    $error("out_quantity: expected %0h, actual %0h", exp.out_quantity,
                           got.out_quantity);
                    fail_count++;
                end
                if (got.last != exp.last) begin
                    $error("last: expected %0d, actual %0d", exp.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic obdt_pkg::t_req make_req(t_row w);
        obdt_pkg::t_req r;
        r.command = w.cmd;
        r.side = w.side;
        r.price = w.price;
        r.quantity = w.qty;
        r.first_id = w.first_id;
        r.final_id = w.final_id;
        r.previous_id = w.prev_id;
        r.first_present = w.present[2];
        r.final_present = w.present[1];
        r.previous_present = w.present[0];
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    t_row directed[] = '{
        // book not live
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 0, 5, 0, 3'b010, obdt_pkg::ST_SKIPPED},
        // levels off
        '{obdt_pkg::CMD_SNAP_LEVEL, 0, 10, 1, 0, 0, 0, 3'b000, obdt_pkg::ST_IGNORED},
        // empty book
        '{obdt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 3'b000, -1},
        '{obdt_pkg::CMD_SNAP_START, 0, 0, 0, 0, 100, 0, 3'b010, obdt_pkg::ST_APPLIED},
        '{obdt_pkg::CMD_SNAP_LEVEL, 0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 0,
          3'b000, obdt_pkg::ST_APPLIED},
        '{obdt_pkg::CMD_SNAP_LEVEL, 0, 0, 1, 0, 0, 0, 3'b000, obdt_pkg::ST_APPLIED},
        '{obdt_pkg::CMD_SNAP_LEVEL, 1, 0, 7, 0, 0, 0, 3'b000, obdt_pkg::ST_APPLIED},
        // zero qty in snapshot
        '{obdt_pkg::CMD_SNAP_LEVEL, 1, 50, 0, 0, 0, 0, 3'b000, obdt_pkg::ST_IGNORED},
        // old id
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 0, 100, 0, 3'b010, obdt_pkg::ST_SKIPPED},
        // previous mismatch
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 0, 110, 99, 3'b011, obdt_pkg::ST_GAP},
        '{obdt_pkg::CMD_UPD_LEVEL, 0, 5, 5, 0, 0, 0, 3'b000, obdt_pkg::ST_IGNORED},
        // bridge fails
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 102, 110, 0, 3'b110, obdt_pkg::ST_GAP},
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 101, 110, 0, 3'b110, obdt_pkg::ST_APPLIED},
        // replace
        '{obdt_pkg::CMD_UPD_LEVEL, 0, 0, 9, 0, 0, 0, 3'b000, obdt_pkg::ST_APPLIED},
        // erase absent
        '{obdt_pkg::CMD_UPD_LEVEL, 1, 77, 0, 0, 0, 0, 3'b000, obdt_pkg::ST_APPLIED},
        // erase
        '{obdt_pkg::CMD_UPD_LEVEL, 1, 0, 0, 0, 0, 0, 3'b000, obdt_pkg::ST_APPLIED},
        // no final id
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 0, 0, 110, 3'b001, obdt_pkg::ST_APPLIED},
        '{obdt_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0, 3'b000, -1},
        '{3'd6, 1, 0, 0, 0, 0, 0, 3'b111, obdt_pkg::ST_IGNORED},
        '{3'd7, 0, 0, 0, 0, 0, 0, 3'b000, obdt_pkg::ST_IGNORED},
        '{obdt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 3'b000, obdt_pkg::ST_APPLIED},
        // stale
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 0, 200, 0, 3'b010, obdt_pkg::ST_SKIPPED},
        '{obdt_pkg::CMD_SNAP_START, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 3'b010,
          obdt_pkg::ST_APPLIED},
        '{obdt_pkg::CMD_UPD_START, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 3'b110,
          obdt_pkg::ST_SKIPPED}
    };

    task automatic fill_side_full(bit s);
        obdt_pkg::t_req r;
        r = '0;
        r.command = obdt_pkg::CMD_SNAP_START;
        send_request(r, obdt_pkg::ST_APPLIED);
        for (int i = 0; i <= obdt_pkg::BookDepth; i++) begin
            r = '0;
            r.command = obdt_pkg::CMD_SNAP_LEVEL;
            r.side = s;
            r.price = 48'd1000 + 48'(i * 3);
            r.quantity = 48'(i + 1);
            send_request(r, i < obdt_pkg::BookDepth ? obdt_pkg::ST_APPLIED
                                                    : obdt_pkg::ST_FULL);
        end
        r.price = 48'd1000;
        r.quantity = 48'd55;
        send_request(r, obdt_pkg::ST_APPLIED);   // existing price on full side
        r.command = obdt_pkg::CMD_QUERY;
        send_request(r, -1);
    endtask

    function automatic obdt_pkg::t_req random_req(logic [47:0] base);
        obdt_pkg::t_req r;
        int roll;
        r = '0;
        roll = $urandom_range(0, 99);
        r.side = 1'($urandom_range(0, 1));
        r.price = ($urandom_range(0, 9) == 0) ? rand48() : base + 48'($urandom_range(0, 40));
        r.quantity = ($urandom_range(0, 5) == 0) ? 48'd0 :
                     (($urandom_range(0, 9) == 0) ? rand48() :
                                                    48'($urandom_range(1, 999)));
        r.first_present = 1'($urandom_range(0, 1));
        r.final_present = ($urandom_range(0, 3) != 0);
        r.previous_present = 1'($urandom_range(0, 1));
        if (seen_ok && $urandom_range(0, 3) != 0) begin
            r.previous_id = seen_id;
            r.first_id = seen_id + 64'd1 - 64'($urandom_range(0, 2));
            r.final_id = seen_id + 64'($urandom_range(1, 20));
        end else begin
            r.previous_id = rand64();
            r.first_id = rand64();
            r.final_id = rand64();
        end
        if (roll < 4) r.command = obdt_pkg::CMD_SNAP_START;
        else if (roll < 14) r.command = obdt_pkg::CMD_SNAP_LEVEL;
        else if (roll < 30) r.command = obdt_pkg::CMD_UPD_START;
        else if (roll < 80) r.command = obdt_pkg::CMD_UPD_LEVEL;
        else if (roll < 83) r.command = obdt_pkg::CMD_CLEAR;
        else if (roll < 97) r.command = obdt_pkg::CMD_QUERY;
        else r.command = 3'($urandom_range(6, 7));
        return r;
    endfunction

    initial begin
        int waited;
        obdt_pkg::t_req r;
        logic [47:0] base;
        req_bus.valid = 1'b0;
        req_bus.data = '0;
        fail_count = 0;
        rsp_count = 0;
        seen_id = '0;
        seen_ok = 0;
        live = 0;
        stale = 0;
        levels_on = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_request(make_req(directed[i]), directed[i].want);
        fill_side_full(0);
        fill_side_full(1);

        // random traffic: mostly a fresh snapshot followed by chained updates
        base = rand48();
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 60 == 0) base = ($urandom_range(0, 1)) ? rand48() : 48'd500;
            r = random_req(base);
            send_request(r, -1);
        end
        req_bus.valid <= 1'b0;

        waited = 0;
        while (expected_rsp.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d results: applied %0d, skipped %0d, gap %0d, ignored %0d, full %0d",
                 rsp_count, status_hits[0], status_hits[1], status_hits[2],
                 status_hits[3], status_hits[4]);
        if (fail_count == 0 && expected_rsp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
